[sv/ced_pkg.sv]
// types and constants shared by the binding digest modules
// no dependencies
package ced_pkg;

	localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
	localparam logic [63:0] SEED_AT_RESET = 64'd1469598103934665603;
	localparam logic [7:0] TEXT_END_BYTE = 8'hff;
	localparam logic [7:0] MIN_PRINTABLE = 8'h20;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_BAD_CLAIM = 3'd1;
	localparam logic [2:0] ST_BAD_COUNT = 3'd2;
	localparam logic [2:0] ST_BAD_TEXT = 3'd3;
	localparam logic [2:0] ST_DUPLICATE = 3'd4;

	localparam logic [1:0] REF_ERR_NONE = 2'd0;
	localparam logic [1:0] REF_ERR_TEXT = 2'd1;
	localparam logic [1:0] REF_ERR_DUP = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last_in_text;
		logic last_text;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] digest;
		logic [2:0] status;
		logic [3:0] reference_count;
	} out_beat_t;

	typedef struct packed {
		logic accept;
		logic hash1;
		logic rd;
		logic chk;
		logic hash2;
		logic fin;
		logic emit;
	} ced_cmd_t;

	typedef struct packed {
		logic need_cmp;
		logic last_cmp;
		logic end_text;
		logic end_bind;
		logic out_free;
	} ced_sts_t;

	function automatic logic [63:0] fnv_mul(input logic [63:0] x);
		fnv_mul = x * FNV_PRIME;
	endfunction

endpackage

[sv/claim_evidence_binding_digest.sv]
// Binding digest: takes one byte per beat and keeps a 64-bit FNV-1a digest with a 0xff marker
// after each text, checking claim and reference texts. Each byte is accepted, goes through a
// constant multiply, then a read and a compare for every earlier reference it is compared
// against through the single read port of the reference store, then a second multiply on the
// last byte of a text, then bookkeeping; at binding end a last step loads the result register.
// depends on ced_pkg, ced_ctrl, ced_dp
module claim_evidence_binding_digest import ced_pkg::*; #(
	parameter int CLAIM_LIMIT = 256,
	parameter int REF_LIMIT = 64,
	parameter int EVIDENCE_LIMIT = 8
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_beat_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_beat_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [63:0] cfg_data
);
	ced_cmd_t cmd;
	ced_sts_t sts;

	assign cfg_ready = 1'b1;

	ced_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts(sts),
		.cmd(cmd)
	);

	ced_dp #(
		.CLAIM_LIMIT(CLAIM_LIMIT),
		.REF_LIMIT(REF_LIMIT),
		.EVIDENCE_LIMIT(EVIDENCE_LIMIT)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.cfg_valid(cfg_valid),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.sts(sts),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);
endmodule

[sv/ced_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
module ced_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[sv/ced_ctrl.sv]
// controller state machine for the binding digest
// depends on ced_pkg
module ced_ctrl import ced_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input ced_sts_t sts,
	output ced_cmd_t cmd
);
	typedef enum logic [2:0] {IDLE, HASH1, RD, CHK, HASH2, FIN, EMIT} state_t;
	state_t state_q;

	assign in_ready = (state_q == IDLE);

	always_comb begin
		cmd = '0;
		cmd.accept = (state_q == IDLE) && in_valid;
		cmd.hash1 = (state_q == HASH1);
		cmd.rd = (state_q == RD);
		cmd.chk = (state_q == CHK);
		cmd.hash2 = (state_q == HASH2);
		cmd.fin = (state_q == FIN);
		cmd.emit = (state_q == EMIT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE: if (in_valid) state_q <= HASH1;
				HASH1: begin
					if (sts.need_cmp) state_q <= RD;
					else if (sts.end_text) state_q <= HASH2;
					else state_q <= FIN;
				end
				RD: state_q <= CHK;
				CHK: begin
					if (!sts.last_cmp) state_q <= RD;
					else if (sts.end_text) state_q <= HASH2;
					else state_q <= FIN;
				end
				HASH2: state_q <= FIN;
				FIN: state_q <= sts.end_bind ? EMIT : IDLE;
				EMIT: if (sts.out_free) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

[sv/ced_dp.sv]
// datapath: digest, text bookkeeping, reference store and result register
// depends on ced_pkg, ced_ram
module ced_dp import ced_pkg::*; #(
	parameter int CLAIM_LIMIT = 256,
	parameter int REF_LIMIT = 64,
	parameter int EVIDENCE_LIMIT = 8
) (
	input logic clk,
	input logic arst_n,
	input in_beat_t in_data,
	input logic cfg_valid,
	input logic [63:0] cfg_data,
	input ced_cmd_t cmd,
	output ced_sts_t sts,
	output logic out_valid,
	input logic out_ready,
	output out_beat_t out_data
);
	localparam int PMAX = (CLAIM_LIMIT > REF_LIMIT) ? CLAIM_LIMIT : REF_LIMIT;
	localparam int PW = $clog2(PMAX + 1);
	localparam int TW = $clog2(EVIDENCE_LIMIT + 3);
	localparam int IW = (EVIDENCE_LIMIT > 1) ? $clog2(EVIDENCE_LIMIT) : 1;
	localparam int LW = $clog2(REF_LIMIT);
	localparam int DEPTH = EVIDENCE_LIMIT * REF_LIMIT;
	localparam int AW = $clog2(DEPTH);

	logic [63:0] seed_q, dig_q;
	logic [TW-1:0] tn_q;
	logic [PW-1:0] pos_q;
	logic claim_failed_q;
	logic [1:0] fre_q;
	logic [EVIDENCE_LIMIT-1:0] sm_q;
	logic [LW-1:0] len_q [EVIDENCE_LIMIT];
	logic [7:0] b_q;
	logic end_text_q, end_bind_q, tracked_q;
	logic [IW-1:0] j_q;
	logic [IW-1:0] ri;
	logic [TW-1:0] ri_full;
	logic [PW-1:0] limit;
	logic bad, in_range;
	logic [AW-1:0] waddr, raddr;
	logic [7:0] rdata;
	logic [EVIDENCE_LIMIT-1:0] dup_vec;
	logic [TW-1:0] refs;
	logic [2:0] status;

	assign ri_full = tn_q - TW'(1);
	assign ri = ri_full[IW-1:0];
	assign in_range = (tn_q != '0) && (ri_full < TW'(EVIDENCE_LIMIT));
	assign limit = (tn_q == '0) ? PW'(CLAIM_LIMIT) : PW'(REF_LIMIT);
	assign bad = (in_data.data_byte < MIN_PRINTABLE) ||
		({1'b0, pos_q} + (PW+1)'(1) >= {1'b0, limit});

	assign waddr = AW'(ri * REF_LIMIT) + AW'(pos_q);
	assign raddr = AW'(j_q * REF_LIMIT) + AW'(pos_q);

	ced_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
		.clk(clk),
		.we(cmd.accept && in_range && fre_q == REF_ERR_NONE && !bad),
		.waddr(waddr),
		.wdata(in_data.data_byte),
		.re(cmd.rd),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		for (int j = 0; j < EVIDENCE_LIMIT; j++) begin
			dup_vec[j] = (IW'(j) < ri) && sm_q[j] &&
				({1'b0, len_q[j]} == (LW+1)'(pos_q) + (LW+1)'(1));
		end
	end

	assign sts.need_cmp = tracked_q && (ri != '0);
	assign sts.last_cmp = (j_q == ri - IW'(1));
	assign sts.end_text = end_text_q;
	assign sts.end_bind = end_bind_q;
	assign sts.out_free = !out_valid || out_ready;

	assign refs = tn_q - TW'(1);
	always_comb begin
		if (claim_failed_q) status = ST_BAD_CLAIM;
		else if (refs == '0 || refs > TW'(EVIDENCE_LIMIT)) status = ST_BAD_COUNT;
		else if (fre_q == REF_ERR_TEXT) status = ST_BAD_TEXT;
		else if (fre_q == REF_ERR_DUP) status = ST_DUPLICATE;
		else status = ST_OK;
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			b_q <= in_data.data_byte;
			end_bind_q <= in_data.last_text;
			end_text_q <= in_data.last_in_text || in_data.last_text;
			tracked_q <= in_range && fre_q == REF_ERR_NONE && !bad;
			j_q <= '0;
			dig_q <= ((tn_q == '0 && pos_q == '0) ? seed_q : dig_q) ^ {56'd0, in_data.data_byte};
		end
		if (cmd.hash1) dig_q <= fnv_mul(dig_q);
		if (cmd.hash2) dig_q <= fnv_mul(dig_q ^ {56'd0, TEXT_END_BYTE});
		if (cmd.chk) j_q <= j_q + IW'(1);
		if (cmd.fin && end_text_q && tracked_q) len_q[ri] <= LW'(pos_q) + LW'(1);
		if (cmd.emit) begin
			out_data.digest <= (status == ST_OK) ? dig_q : 64'd0;
			out_data.status <= status;
			out_data.reference_count <= (refs > TW'(EVIDENCE_LIMIT)) ?
				4'(EVIDENCE_LIMIT) : 4'(refs);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_AT_RESET;
			tn_q <= '0;
			pos_q <= '0;
			claim_failed_q <= 1'b0;
			fre_q <= REF_ERR_NONE;
			sm_q <= '1;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid) seed_q <= cfg_data;
			if (cmd.emit) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			if (cmd.accept && bad) begin
				if (tn_q == '0) claim_failed_q <= 1'b1;
				else if (in_range && fre_q == REF_ERR_NONE) fre_q <= REF_ERR_TEXT;
			end
			// earlier reference drops out once it differs or runs out
			if (cmd.chk && sm_q[j_q] &&
				(pos_q >= PW'(len_q[j_q]) || rdata != b_q)) begin
				sm_q[j_q] <= 1'b0;
			end
			if (cmd.fin) begin
				if (end_text_q) begin
					if (tracked_q && |dup_vec) fre_q <= REF_ERR_DUP;
					sm_q <= '1;
					pos_q <= '0;
					if (tn_q <= TW'(EVIDENCE_LIMIT + 1)) tn_q <= tn_q + TW'(1);
				end else if (pos_q < limit) begin
					pos_q <= pos_q + PW'(1);
				end
			end
			if (cmd.emit) begin
				tn_q <= '0;
				pos_q <= '0;
				claim_failed_q <= 1'b0;
				fre_q <= REF_ERR_NONE;
				sm_q <= '1;
			end
		end
	end
endmodule

[sv/ced_checker.sv]
// port level checks for the binding digest, bound to the top level
// depends on ced_pkg
module ced_checker import ced_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_beat_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped while stalled");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.digest == 64'd0)
		else $error("nonzero digest on error");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= ST_DUPLICATE)
		else $error("bad status code");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_OK |-> out_data.reference_count != 4'd0)
		else $error("ok with no references");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second beat taken before byte finished");
endmodule

bind claim_evidence_binding_digest ced_checker u_ced_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);
